@@ src/hsc_pkg.sv @@
// Shared constants for the hyperbolic soft clipper.
package hsc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int THR_W           = 15;
  localparam int KNEE_W          = 29;

  localparam logic [THR_W-1:0]  THR_RESET  = 15'd23198;
  localparam logic [KNEE_W-1:0] KNEE_RESET = KNEE_W'(23198 * 32768 - 23198 * 23198);

endpackage

@@ src/hsc_if.sv @@
// Valid/ready channel interfaces for samples and the threshold register.
interface hsc_in_if
  import hsc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface hsc_out_if
  import hsc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface hsc_cfg_if
  import hsc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] threshold_gain;

  modport source (output valid, output threshold_gain, input ready);
  modport sink   (input valid, input threshold_gain, output ready);
endinterface

@@ src/hsc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with elastic flow control.
module hsc_div_pipe #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 16,
  parameter int QUO_W = 16,
  parameter int TAG_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             rem_nz_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic             v_q   [QUO_W];
  logic [RW-1:0]    rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];
  logic [QUO_W:0]   en;

  assign en[QUO_W] = out_ready_i;
  assign in_ready_o = en[0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;

    logic             v_in;
    logic [RW-1:0]    rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [RW-1:0]    trial;
    logic [RW-1:0]    rem_sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = RW'(num_i);
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial   = RW'(den_in) << B;
    assign ge      = (rem_in >= trial);
    assign rem_sub = rem_in - trial;
    assign en[k]   = ~v_q[k] | en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && v_in) begin
        rem_q[k] <= ge ? rem_sub : rem_in;
        quo_q[k] <= quo_in | (QUO_W'(ge) << B);
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign out_valid_o = v_q[QUO_W-1];
  assign quo_o       = quo_q[QUO_W-1];
  assign rem_nz_o    = |rem_q[QUO_W-1];
  assign tag_o       = tag_q[QUO_W-1];

endmodule

@@ src/hyperbolic_soft_clipper.sv @@
// Hyperbolic soft clipper: top level with register, pipeline ends and divider.
//
// Channels: in_i takes one signed Q1.F sample per request (F = SAMPLE_BITS-1),
// out_o gives one clipped sample per request in the same order, cfg_i writes
// the 15-bit Q0.15 threshold. cfg_i is always ready; write it only while no
// sample is in flight.
// Samples at or below the threshold pass unchanged; above it the magnitude
// becomes (|x| - (t - t*t)) / |x|, rounded toward zero, saturated at 2^F-1.
// Pipeline: one input stage (magnitude, clip compare), SAMPLE_BITS divider
// stages that each resolve one quotient bit, one rounding stage and the
// output register. Throughput: one sample per cycle while the receiver is
// ready, set by the one-bit-per-stage divider.
// Reset empties the pipeline and sets the threshold to 23198 (about -3 dB).
// When the receiver stalls, each stage holds its sample and empty stages
// keep filling; in_i.ready falls only once every stage holds a sample.
module hyperbolic_soft_clipper
  import hsc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsc_cfg_if.sink   cfg_i,
  hsc_in_if.sink    in_i,
  hsc_out_if.source out_o
);

  localparam int F    = SAMPLE_BITS - 1;
  localparam int QW   = SAMPLE_BITS;
  localparam int NSH  = (2 * F >= 30) ? 2 * F - 30 : 0;
  localparam int DSH  = (2 * F >= 30) ? 0 : 30 - 2 * F;
  localparam int NW   = KNEE_W + NSH;
  localparam int DW   = QW + DSH;
  localparam int TW   = SAMPLE_BITS + 1;
  localparam int CMPW = SAMPLE_BITS + THR_W;

  localparam logic [QW:0]   FULL  = (QW + 1)'(1) << F;
  localparam logic [QW-1:0] SAT_Y = QW'(FULL - (QW + 1)'(1));

  // threshold register and derived knee constant t - t*t in Q0.30
  logic [THR_W-1:0]    thr_q;
  logic [KNEE_W-1:0]   knee_q;
  logic [2*THR_W-1:0]  thr_sq;
  logic [2*THR_W-1:0]  thr_hi;

  assign cfg_i.ready = 1'b1;
  assign thr_sq      = (2 * THR_W)'(cfg_i.threshold_gain) * (2 * THR_W)'(cfg_i.threshold_gain);
  assign thr_hi      = {cfg_i.threshold_gain, {THR_W{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      knee_q <= KNEE_RESET;
    end else if (cfg_i.valid) begin
      thr_q  <= cfg_i.threshold_gain;
      knee_q <= KNEE_W'(thr_hi - thr_sq);
    end
  end

  // flow control
  logic s0_v_q, f_v_q, out_v_q;
  logic en_s0, en_f, en_out;
  logic div_in_ready, div_out_valid;

  assign en_out    = ~out_v_q | out_o.ready;
  assign en_f      = ~f_v_q | en_out;
  assign en_s0     = ~s0_v_q | div_in_ready;
  assign in_i.ready = en_s0;

  // input stage: magnitude, clip decision, divider operands
  logic [QW-1:0]          mag_d;
  logic                   clip_d;
  logic [SAMPLE_BITS-1:0] s0_raw_q;
  logic                   s0_clip_q;
  logic [NW-1:0]          s0_num_q;
  logic [DW-1:0]          s0_den_q;

  assign mag_d  = in_i.sample_in[SAMPLE_BITS-1]
                  ? QW'(~in_i.sample_in + SAMPLE_BITS'(1))
                  : QW'(in_i.sample_in);
  assign clip_d = ({mag_d, {THR_W{1'b0}}} > (CMPW'(thr_q) << F));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en_s0) begin
      s0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s0 && in_i.valid) begin
      s0_raw_q  <= in_i.sample_in;
      s0_clip_q <= clip_d;
      s0_num_q  <= NW'(knee_q) << NSH;
      s0_den_q  <= DW'(mag_d) << DSH;
    end
  end

  // divider
  logic [QW-1:0] quo;
  logic          rem_nz;
  logic [TW-1:0] div_tag;

  hsc_div_pipe #(
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (QW),
    .TAG_W (TW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_v_q),
    .in_ready_o  (div_in_ready),
    .num_i       (s0_num_q),
    .den_i       (s0_den_q),
    .tag_i       ({s0_clip_q, s0_raw_q}),
    .out_valid_o (div_out_valid),
    .out_ready_i (en_f),
    .quo_o       (quo),
    .rem_nz_o    (rem_nz),
    .tag_o       (div_tag)
  );

  // rounding stage: ceil quotient, subtract from full scale, saturate
  logic [QW:0]            ceil_q;
  logic [QW-1:0]          ymag_d;
  logic [QW-1:0]          f_ymag_q;
  logic [SAMPLE_BITS-1:0] f_raw_q;
  logic                   f_clip_q;

  assign ceil_q = (QW + 1)'(quo) + (QW + 1)'(rem_nz);

  always_comb begin
    if (ceil_q == '0) begin
      ymag_d = SAT_Y;
    end else if (ceil_q >= FULL) begin
      ymag_d = '0;
    end else begin
      ymag_d = QW'(FULL - ceil_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en_f) begin
      f_v_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_f && div_out_valid) begin
      f_ymag_q <= ymag_d;
      f_raw_q  <= div_tag[SAMPLE_BITS-1:0];
      f_clip_q <= div_tag[SAMPLE_BITS];
    end
  end

  // output register: apply sign or pass the sample through
  logic [SAMPLE_BITS-1:0] out_d;
  logic [SAMPLE_BITS-1:0] out_q;

  always_comb begin
    if (!f_clip_q) begin
      out_d = f_raw_q;
    end else if (f_raw_q[SAMPLE_BITS-1]) begin
      out_d = SAMPLE_BITS'(~f_ymag_q + QW'(1));
    end else begin
      out_d = SAMPLE_BITS'(f_ymag_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && f_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.sample_out = out_q;

`ifndef SYNTHESIS
  a_clip_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_v_q && s0_clip_q |-> s0_den_q != '0)
    else $error("clipped sample reached the divider with a zero divisor");

  a_quo_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_out_valid && div_tag[SAMPLE_BITS] |-> (quo[F] == 1'b0) || (quo[F-1:0] == '0))
    else $error("clip quotient exceeds full scale");

  a_ymag_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q && f_clip_q |-> f_ymag_q[F] == 1'b0)
    else $error("clipped magnitude not saturated");

  a_out_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_out && f_v_q && f_clip_q && (f_ymag_q != '0)
      |=> out_o.sample_out[SAMPLE_BITS-1] == $past(f_raw_q[SAMPLE_BITS-1]))
    else $error("clipped output lost the input sign");
`endif

endmodule
